@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file fetl_chk
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define FETL_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("fetl assertion failed");

// next-cycle implication, reset masks the check
`define FETL_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("fetl assertion failed");

`endif

@@ rtl/core/fetl_pkg.sv @@
// shared types, codes and constants of the fat16 extent table
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fetl_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEED,
		ST_ADD,
		ST_WALK,
		ST_POST
	} fetl_state_t;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_ADD    = 2'd1;
	localparam logic [1:0] MODE_FAT    = 2'd2;
	localparam logic [1:0] MODE_LOCATE = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_NOSPACE = 2'd2;

	localparam logic [15:0] FIRST_CLUSTER = 16'd2;
	localparam logic [15:0] FAT_MEDIA     = 16'hFFF8;
	localparam logic [15:0] FAT_CLEAN     = 16'h8000;
	localparam logic [15:0] FAT_EOC       = 16'hFFFF;
	localparam logic [17:0] CLUSTER_LIMIT = 18'h10000;
	localparam logic [4:0]  SPC_LOG2      = 5'd7;
	localparam logic [3:0]  SSZ_MIN       = 4'd9;
	localparam logic [3:0]  SSZ_MAX       = 4'd12;
	localparam logic [3:0]  SSZ_RESET     = 4'd9;

	// query token that walks the cell chain
	typedef struct packed {
		logic        vld;
		logic        locate;
		logic [15:0] fat_index;
		logic [31:0] data_offset;
		logic [4:0]  sh;
		logic        found;
		logic        hit;
		logic [3:0]  file_number;
		logic [31:0] offset_in_file;
		logic [15:0] entry_value;
	} fetl_tok_t;

	// extent write broadcast to the cells
	typedef struct packed {
		logic        en;
		logic [15:0] start;
		logic [15:0] clusters;
		logic [31:0] bytes;
	} fetl_wr_t;

	// byte shift of one cluster, sector size clamped to 512..4096
	function automatic logic [4:0] fetl_shift(input logic [3:0] ssz);
		logic [3:0] s;
		s = ssz;
		if (s < SSZ_MIN) s = SSZ_MIN;
		if (s > SSZ_MAX) s = SSZ_MAX;
		return {1'b0, s} + SPC_LOG2;
	endfunction

endpackage

@@ rtl/core/fetl_cell.sv @@
// one cell of the extent chain: holds one file extent, tests the passing token
// depends on fetl_pkg
`timescale 1ns / 1ps

module fetl_cell import fetl_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 5,
	parameter int IW  = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fetl_wr_t        wr,
	input  logic [IW-1:0]   wr_idx,
	input  logic [CW-1:0]   count,
	input  fetl_tok_t       tok_in,
	output fetl_tok_t       tok_out
);

	logic [15:0] st_q;
	logic [15:0] n_q;
	logic [31:0] bytes_q;
	fetl_tok_t   tok_q;
	fetl_tok_t   tok_d;

	logic        active;
	logic [16:0] fat_end;
	logic        fat_in;
	logic        fat_last;
	logic [15:0] cl;
	logic [15:0] rel;
	logic [16:0] rel_end;
	logic        loc_in;
	logic [31:0] base;
	logic [31:0] fo;

	always_ff @(posedge clk) begin
		if (wr.en && wr_idx == IW'(IDX)) begin
			st_q    <= wr.start;
			n_q     <= wr.clusters;
			bytes_q <= wr.bytes;
		end
	end

	always_comb begin
		active   = tok_in.vld && !tok_in.found && (CW'(IDX) < count);
		fat_end  = {1'b0, st_q} + {1'b0, n_q};
		fat_in   = (n_q != 16'd0) && (tok_in.fat_index >= st_q)
			&& ({1'b0, tok_in.fat_index} < fat_end);
		fat_last = {1'b0, tok_in.fat_index} == (fat_end - 17'd1);
		cl       = 16'(tok_in.data_offset >> tok_in.sh);
		rel      = st_q - FIRST_CLUSTER;
		rel_end  = {1'b0, rel} + {1'b0, n_q};
		loc_in   = (n_q != 16'd0) && (st_q >= FIRST_CLUSTER) && (cl >= rel)
			&& ({1'b0, cl} < rel_end);
		// upper bits lost here only when the cluster test fails
		base     = {16'd0, rel} << tok_in.sh;
		fo       = tok_in.data_offset - base;

		tok_d = tok_in;
		if (active) begin
			if (!tok_in.locate) begin
				if (fat_in) begin
					tok_d.found       = 1'b1;
					tok_d.entry_value = fat_last ? FAT_EOC : tok_in.fat_index + 16'd1;
				end
			end else if (loc_in) begin
				tok_d.found = 1'b1;
				if (fo < bytes_q) begin
					tok_d.hit            = 1'b1;
					tok_d.file_number    = 4'(IDX);
					tok_d.offset_in_file = fo;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

@@ rtl/core/fat16_extent_table_chain_lookup.sv @@
// top level of the fat16 extent table: control sequencer plus a chain of extent cells
// depends on fetl_pkg and fetl_cell
`timescale 1ns / 1ps

// One operation is in flight at a time. A clear goes from the input transfer
// straight to the result post state, an add first rounds up the cluster count and
// then does the space check and the table write, and a FAT word read or a data
// offset lookup waits while the query token passes one extent cell per cycle down
// the chain. The result then moves into the output register once that is free, and
// the input side reopens in the same cycle. The output register frees the input
// side: a new transfer is taken as soon as the previous result sits in it, even if
// it has not yet been taken. The sector size register may be written at any
// time the block is idle; cfg_ready is always high. Values below 9 act as 9 and
// values above 12 act as 12. Table entries need no clearing after reset.

module fat16_extent_table_chain_lookup import fetl_pkg::*; #(
	parameter int MAX_FILES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  sector_size_log2,
	// command channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] file_size,
	input  logic [15:0] fat_index,
	input  logic [31:0] data_offset,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] start_cluster,
	output logic [15:0] entry_value,
	output logic        hit,
	output logic [3:0]  file_number,
	output logic [31:0] offset_in_file
);

	localparam int CW = $clog2(MAX_FILES + 1);
	localparam int IW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;

	fetl_state_t state_q;
	fetl_state_t state_d;

	logic [3:0]    cfg_q;
	logic [CW-1:0] count_q;
	logic [15:0]   nf_q;
	logic [31:0]   size_q;
	logic [16:0]   need_q;
	fetl_tok_t     inj_q;

	// finished result waiting for the output register
	logic [1:0]  res_status_q;
	logic [15:0] res_start_q;
	logic [15:0] res_entry_q;
	logic        res_hit_q;
	logic [3:0]  res_fn_q;
	logic [31:0] res_off_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [15:0] start_q;
	logic [15:0] entry_q;
	logic        hit_q;
	logic [3:0]  fn_q;
	logic [31:0] off_q;

	logic        in_xfer;
	logic        post_go;
	logic        full;
	logic [4:0]  sh_w;
	logic [31:0] mask_w;
	logic [32:0] round_w;
	logic [16:0] need_w;
	logic [17:0] add_end;
	logic        nospace;
	fetl_wr_t    wr_w;
	logic [IW-1:0] wr_idx_w;
	fetl_tok_t   chain_w [MAX_FILES+1];

	assign cfg_ready = 1'b1;
	assign sh_w      = fetl_shift(cfg_q);

	// bytes -> clusters with round-up
	assign mask_w  = ~(32'hFFFF_FFFF << sh_w);
	assign round_w = {1'b0, size_q} + {1'b0, mask_w};
	assign need_w  = 17'(round_w >> sh_w);

	// space check against the 16-bit cluster range
	assign add_end = 18'(nf_q) + 18'(need_q);
	assign nospace = add_end >= CLUSTER_LIMIT;
	assign full    = count_q >= CW'(MAX_FILES);

	// table write, new slot is the current file count
	always_comb begin
		wr_w.en       = (state_q == ST_ADD) && !full && ((size_q == 32'd0) || !nospace);
		wr_w.start    = (size_q == 32'd0) ? 16'd0 : nf_q;
		wr_w.clusters = (size_q == 32'd0) ? 16'd0 : need_q[15:0];
		wr_w.bytes    = size_q;
	end
	assign wr_idx_w = count_q[IW-1:0];

	// sequencer: next state and handshakes
	always_comb begin
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		in_xfer  = in_valid && in_ready;
		post_go  = (state_q == ST_POST) && (!out_valid_q || out_ready);
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (mode)
						MODE_CLEAR: state_d = ST_POST;
						MODE_ADD:   state_d = ST_NEED;
						default:    state_d = ST_WALK;
					endcase
				end
			end
			ST_NEED: state_d = ST_ADD;
			ST_ADD:  state_d = ST_POST;
			ST_WALK: begin
				if (chain_w[MAX_FILES].vld) state_d = ST_POST;
			end
			ST_POST: begin
				if (post_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sector size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= SSZ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= sector_size_log2;
		end
	end

	// table bookkeeping, token injection and result capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			nf_q         <= FIRST_CLUSTER;
			size_q       <= '0;
			need_q       <= '0;
			inj_q        <= '0;
			res_status_q <= STAT_OK;
			res_start_q  <= '0;
			res_entry_q  <= '0;
			res_hit_q    <= 1'b0;
			res_fn_q     <= '0;
			res_off_q    <= '0;
		end else begin
			if (state_q != ST_IDLE) inj_q.vld <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					inj_q.vld <= in_xfer && ((mode == MODE_FAT) || (mode == MODE_LOCATE));
					if (in_xfer) begin
						size_q       <= file_size;
						res_status_q <= STAT_OK;
						res_start_q  <= '0;
						res_entry_q  <= '0;
						res_hit_q    <= 1'b0;
						res_fn_q     <= '0;
						res_off_q    <= '0;
						if (mode == MODE_CLEAR) begin
							count_q <= '0;
							nf_q    <= FIRST_CLUSTER;
						end
						inj_q.locate         <= (mode == MODE_LOCATE);
						inj_q.fat_index      <= fat_index;
						inj_q.data_offset    <= data_offset;
						inj_q.sh             <= sh_w;
						// reserved fat words settle before the walk
						inj_q.found          <= (mode == MODE_FAT) && (fat_index < 16'd2);
						inj_q.hit            <= 1'b0;
						inj_q.file_number    <= '0;
						inj_q.offset_in_file <= '0;
						if (mode == MODE_FAT && fat_index == 16'd0) begin
							inj_q.entry_value <= FAT_MEDIA;
						end else if (mode == MODE_FAT && fat_index == 16'd1) begin
							inj_q.entry_value <= FAT_CLEAN;
						end else begin
							inj_q.entry_value <= '0;
						end
					end
				end
				ST_NEED: need_q <= need_w;
				ST_ADD: begin
					if (full) begin
						res_status_q <= STAT_FULL;
					end else if (size_q == 32'd0) begin
						count_q <= count_q + CW'(1);
					end else if (nospace) begin
						res_status_q <= STAT_NOSPACE;
					end else begin
						count_q     <= count_q + CW'(1);
						nf_q        <= add_end[15:0];
						res_start_q <= nf_q;
					end
				end
				ST_WALK: begin
					if (chain_w[MAX_FILES].vld) begin
						res_entry_q <= chain_w[MAX_FILES].entry_value;
						res_hit_q   <= chain_w[MAX_FILES].hit;
						res_fn_q    <= chain_w[MAX_FILES].file_number;
						res_off_q   <= chain_w[MAX_FILES].offset_in_file;
					end
				end
				default: ;
			endcase
		end
	end

	// output register, one result deep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= STAT_OK;
			start_q     <= '0;
			entry_q     <= '0;
			hit_q       <= 1'b0;
			fn_q        <= '0;
			off_q       <= '0;
		end else begin
			out_valid_q <= post_go || (out_valid_q && !out_ready);
			if (post_go) begin
				status_q    <= res_status_q;
				start_q     <= res_start_q;
				entry_q     <= res_entry_q;
				hit_q       <= res_hit_q;
				fn_q        <= res_fn_q;
				off_q       <= res_off_q;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign start_cluster  = start_q;
	assign entry_value    = entry_q;
	assign hit            = hit_q;
	assign file_number    = fn_q;
	assign offset_in_file = off_q;

	// chain of extent cells, the token moves one cell per cycle
	assign chain_w[0] = inj_q;

	for (genvar g = 0; g < MAX_FILES; g++) begin : g_cell
		fetl_cell #(
			.IDX (g),
			.CW  (CW),
			.IW  (IW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr_w),
			.wr_idx  (wr_idx_w),
			.count   (count_q),
			.tok_in  (chain_w[g]),
			.tok_out (chain_w[g+1])
		);
	end

endmodule

@@ rtl/core/fetl_chk.sv @@
// port-level checker for the fat16 extent table, bound to the top level
// depends on fetl_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fetl_chk import fetl_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [15:0] start_cluster,
	input logic [15:0] entry_value,
	input logic        hit,
	input logic [3:0]  file_number,
	input logic [31:0] offset_in_file
);

	logic fail_quiet;
	logic miss_quiet;
	logic alloc_ok;

	assign fail_quiet = start_cluster == 16'd0 && entry_value == 16'd0 && !hit;
	assign miss_quiet = file_number == 4'd0 && offset_in_file == 32'd0;
	assign alloc_ok   = start_cluster >= FIRST_CLUSTER && entry_value == 16'd0 && !hit;

	// a pending result is not dropped
	`FETL_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	`FETL_ASSERT_IMP(a_status_code, clk, arst_n, out_valid, status <= STAT_NOSPACE)

	// a failed add reports nothing else
	`FETL_ASSERT_IMP(a_fail_clean, clk, arst_n, out_valid && status != STAT_OK, fail_quiet)

	// a miss carries no file position
	`FETL_ASSERT_IMP(a_miss_clean, clk, arst_n, out_valid && !hit, miss_quiet)

	// an allocation lands in the data region and is an add result only
	`FETL_ASSERT_IMP(a_alloc_range, clk, arst_n, out_valid && start_cluster != 16'd0, alloc_ok)

endmodule

bind fat16_extent_table_chain_lookup fetl_chk u_fetl_chk (.*);
